/* hw/rtl/mgp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mgp_pkg
// Shared types and constants of the multimode gate processor: register
// indexes, mode codes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package mgp_pkg;

  localparam int TIME_BITS_DEF = 32;  // default width of time arithmetic
  localparam int CFG_W         = 16;  // widest configuration register
  localparam int CFG_IDX_W     = 3;
  localparam int DIV_W         = 16;  // divisor / remainder width
  localparam int PHASE_STEPS   = 8;   // quotient bits of the phase division

  typedef logic [2:0] mode_t;

  // mode codes; codes above MD_CYC act as gate
  localparam mode_t MD_GATE   = 3'd0;
  localparam mode_t MD_TRIG   = 3'd1;
  localparam mode_t MD_TOGGLE = 3'd2;
  localparam mode_t MD_DIV    = 3'd3;
  localparam mode_t MD_CYC    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_PULSE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_RATIO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_PULSE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_PERIOD  = 3'd4;

  // register reset values
  localparam logic [15:0] RST_TRIG_PULSE   = 16'd10;
  localparam logic [7:0]  RST_DIVIDE_RATIO = 8'd2;
  localparam logic [15:0] RST_DIV_PULSE    = 16'd10;
  localparam logic [15:0] RST_CYCLE_PERIOD = 16'd500;

  localparam logic [7:0] ACT_FULL  = 8'd255;
  localparam logic [7:0] PHASE_MID = 8'd128;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_ELAPSE,
    S_MOD,
    S_PHASE,
    S_DONE
  } seq_state_t;

endpackage : mgp_pkg
`default_nettype wire

/* hw/rtl/mgp_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mgp_div
// Shared restoring divider, one quotient bit per cycle. Load a starting
// remainder, a left-aligned dividend and a step count; done pulses once the
// last step has landed in rem and quo.
// ----------------------------------------------------------------------------
module mgp_div #(
  parameter int DW = mgp_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [$clog2(DW+1)-1:0]     steps,
  input  logic [mgp_pkg::DIV_W-1:0]   rem_init,
  input  logic [DW-1:0]               dvd_init,
  input  logic [mgp_pkg::DIV_W-1:0]   divisor,
  output logic                        done,
  output logic [mgp_pkg::DIV_W-1:0]   rem,
  output logic [7:0]                  quo
);
  import mgp_pkg::*;

  localparam int CW = $clog2(DW+1);

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DW-1:0]    sr_r, sr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   trial;
  logic             fits;

  always_comb begin
    trial    = {rem_r, sr_r[DW-1]};
    fits     = (trial >= {1'b0, divisor});
    rem_nxt  = rem_r;
    sr_nxt   = sr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = rem_init;
      sr_nxt   = dvd_init;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      sr_nxt  = {sr_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sr_r  <= sr_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
  assign quo  = sr_r[7:0];

endmodule : mgp_div
`default_nettype wire

/* hw/rtl/multimode_gate_processor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multimode_gate_processor
// Gate / trigger / toggle / clock divider / cycle processor with an
// activity brightness output, built around one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per time tick: the
//   gate level and the current millisecond time (low TIME_BITS bits used).
//   Output channel (out_valid/out_ready) returns one beat per input beat:
//   output level, changed flag and activity brightness.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata);
//   write it only while the block is idle. A write to the mode register
//   clears the mode state.
// Sequencing:
//   Gate, trigger, toggle and divide modes: a beat passes through EVAL and
//   DONE; the next beat is taken only once the sequencer is idle again.
//   Cycle mode: the shared divider first reduces the elapsed time modulo the
//   period (TIME_BITS steps) and then divides by the period for the phase
//   (8 steps); a new beat is taken only after the result has been loaded.
// Reset: synchronous, active low; registers take their reset values, the
//   mode state clears and the output channel empties.
// Stall: the result waits in the output register while out_ready is low;
//   the next input beat is still taken, and its result is held back in the
//   final sequencer state until the output register frees.
// ----------------------------------------------------------------------------
module multimode_gate_processor #(
  parameter int TIME_BITS = mgp_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_gate_in,
  input  logic [31:0]                     in_now_ms,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_gate_out,
  output logic                            out_changed,
  output logic [7:0]                      out_activity_level,
  // configuration port
  input  logic                            cfg_we,
  input  logic [mgp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mgp_pkg::CFG_W-1:0]       cfg_wdata
);
  import mgp_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int CW = $clog2(TB+1);

  // configuration registers
  mode_t       mode_r;
  logic [15:0] trig_pulse_r;
  logic [7:0]  divide_ratio_r;
  logic [15:0] div_pulse_r;
  logic [15:0] cycle_period_r;

  // mode state
  logic          out_level_r, out_level_nxt;
  logic          prev_level_r, prev_level_nxt;
  logic [TB-1:0] mark_r, mark_nxt;
  logic [7:0]    edge_cnt_r, edge_cnt_nxt;
  logic [7:0]    phase_r, phase_nxt;

  // captured beat and pending flag
  logic          gate_r;
  logic [TB-1:0] now_r;
  logic          chg_r, chg_nxt;

  // sequencer
  seq_state_t state_r, state_nxt;
  logic       eval_en, phase_load, out_load, in_take;

  // output register
  logic       out_valid_r;
  logic       out_gate_r;
  logic       out_chg_r;
  logic [7:0] out_act_r;

  // divider hookup
  logic             div_start;
  logic [CW-1:0]    div_steps;
  logic [DIV_W-1:0] div_rem_init;
  logic [TB-1:0]    div_dvd_init;
  logic             div_done;
  logic [DIV_W-1:0] div_rem;
  logic [7:0]       div_quo;

  // step evaluation
  logic          rising, started, fire, pulse_on, expired;
  logic [7:0]    edge_inc;
  logic [15:0]   period, pulse_len;
  logic [14:0]   half;
  logic [TB-1:0] mark_eff, since_mark, elapsed;
  logic [23:0]   prod;
  logic [7:0]    activity;

  assign in_take = in_valid && in_ready;

  // Zero period acts as one millisecond.
  assign period = (cycle_period_r == '0) ? 16'd1 : cycle_period_r;
  assign half   = period[15:1];

  // --------------------------------------------------------------------------
  // Per-mode update of the state for the captured beat
  // --------------------------------------------------------------------------
  always_comb begin
    rising    = gate_r & ~prev_level_r;
    edge_inc  = edge_cnt_r + 8'd1;
    fire      = rising && (edge_inc >= divide_ratio_r);
    started   = 1'b0;
    pulse_len = trig_pulse_r;
    case (mode_r)
      MD_TRIG: begin
        started   = rising;
        pulse_len = trig_pulse_r;
      end
      MD_DIV: begin
        started   = fire;
        pulse_len = div_pulse_r;
      end
      default: begin
        started   = 1'b0;
        pulse_len = trig_pulse_r;
      end
    endcase
    // a fresh pulse measures from now
    mark_eff   = started ? now_r : mark_r;
    since_mark = now_r - mark_eff;
    pulse_on   = started | out_level_r;
    expired    = pulse_on && (since_mark >= TB'(pulse_len));

    out_level_nxt  = out_level_r;
    prev_level_nxt = gate_r;
    mark_nxt       = mark_r;
    edge_cnt_nxt   = edge_cnt_r;
    chg_nxt        = 1'b0;
    case (mode_r)
      MD_TRIG: begin
        out_level_nxt = pulse_on & ~expired;
        mark_nxt      = mark_eff;
        chg_nxt       = started | expired;
      end
      MD_TOGGLE: begin
        out_level_nxt = out_level_r ^ rising;
        chg_nxt       = rising;
      end
      MD_DIV: begin
        if (rising) begin
          edge_cnt_nxt = fire ? 8'd0 : edge_inc;
        end
        out_level_nxt = pulse_on & ~expired;
        mark_nxt      = mark_eff;
        chg_nxt       = started | expired;
      end
      MD_CYC: begin
        // flip once half a period has gone by since the last flip
        if (since_mark >= TB'(half)) begin
          mark_nxt      = now_r;
          out_level_nxt = ~out_level_r;
          chg_nxt       = 1'b1;
        end
      end
      default: begin
        out_level_nxt = gate_r;
        chg_nxt       = (out_level_r != gate_r);
      end
    endcase
  end

  // Time since the start of the current period: while the output is low, the
  // period started half a period before the last flip.
  assign elapsed = now_r - mark_r + (out_level_r ? '0 : TB'(half));

  // pos * 255 as pos * 256 - pos
  assign prod = {div_rem, 8'd0} - {8'd0, div_rem};

  assign phase_nxt = div_quo;

  // triangle of the phase in cycle mode, full or dark elsewhere
  always_comb begin
    if (mode_r == MD_CYC) begin
      if (phase_r < PHASE_MID) begin
        activity = {phase_r[6:0], 1'b0};
      end else begin
        activity = {~phase_r[6:0], 1'b0};
      end
    end else begin
      activity = out_level_r ? ACT_FULL : 8'd0;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = (mode_r == MD_CYC) ? S_ELAPSE : S_DONE;
      end
      S_ELAPSE: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (div_done) begin
          state_nxt = S_PHASE;
        end
      end
      S_PHASE: begin
        if (div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready     = 1'b0;
    eval_en      = 1'b0;
    phase_load   = 1'b0;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_steps    = CW'(TB);
    div_rem_init = '0;
    div_dvd_init = elapsed;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_EVAL: begin
        eval_en = 1'b1;
      end
      S_ELAPSE: begin
        // elapsed modulo the period
        div_start    = 1'b1;
        div_steps    = CW'(TB);
        div_rem_init = '0;
        div_dvd_init = elapsed;
      end
      S_MOD: begin
        // quotient of pos * 255 by the period fits in eight bits
        div_start    = div_done;
        div_steps    = CW'(PHASE_STEPS);
        div_rem_init = prod[23:8];
        div_dvd_init = {prod[7:0], {(TB-8){1'b0}}};
      end
      S_PHASE: begin
        phase_load = div_done;
      end
      S_DONE: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  mgp_div #(
    .DW (TB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .steps    (div_steps),
    .rem_init (div_rem_init),
    .dvd_init (div_dvd_init),
    .divisor  (period),
    .done     (div_done),
    .rem      (div_rem),
    .quo      (div_quo)
  );

  // --------------------------------------------------------------------------
  // Control and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      mode_r         <= MD_GATE;
      trig_pulse_r   <= RST_TRIG_PULSE;
      divide_ratio_r <= RST_DIVIDE_RATIO;
      div_pulse_r    <= RST_DIV_PULSE;
      cycle_period_r <= RST_CYCLE_PERIOD;
      out_level_r    <= 1'b0;
      prev_level_r   <= 1'b0;
      mark_r         <= '0;
      edge_cnt_r     <= '0;
      phase_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: begin
            // any mode write drops the mode state
            mode_r       <= cfg_wdata[2:0];
            out_level_r  <= 1'b0;
            prev_level_r <= 1'b0;
            mark_r       <= '0;
            edge_cnt_r   <= '0;
            phase_r      <= '0;
          end
          REG_TRIG_PULSE:   trig_pulse_r   <= cfg_wdata;
          REG_DIVIDE_RATIO: divide_ratio_r <= cfg_wdata[7:0];
          REG_DIV_PULSE:    div_pulse_r    <= cfg_wdata;
          REG_CYCLE_PERIOD: cycle_period_r <= cfg_wdata;
          default: ;
        endcase
      end else if (eval_en) begin
        out_level_r  <= out_level_nxt;
        prev_level_r <= prev_level_nxt;
        mark_r       <= mark_nxt;
        edge_cnt_r   <= edge_cnt_nxt;
      end else if (phase_load) begin
        phase_r <= phase_nxt;
      end
      // hold until taken, then refill or drop
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      gate_r <= in_gate_in;
      now_r  <= in_now_ms[TB-1:0];
    end
    if (eval_en) begin
      chg_r <= chg_nxt;
    end
    if (out_load) begin
      out_gate_r <= out_level_r;
      out_chg_r  <= chg_r;
      out_act_r  <= activity;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_gate_out       = out_gate_r;
  assign out_changed        = out_chg_r;
  assign out_activity_level = out_act_r;

endmodule : multimode_gate_processor
`default_nettype wire

/* hw/rtl/mgp_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mgp_checker
// Port-level checks of the multimode gate processor, bound to the top level.
// ----------------------------------------------------------------------------
module mgp_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_gate_out,
  input  logic                            out_changed,
  input  logic [7:0]                      out_activity_level
);

  // reset empties the result channel
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // after a take, the input stays closed through EVAL and the state after it
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again too soon");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_gate_out) && $stable(out_changed) && $stable(out_activity_level))
    else $error("result payload changed while stalled");

endmodule : mgp_checker

bind multimode_gate_processor mgp_checker u_mgp_checker (.*);
`default_nettype wire
